// ===== rtl/ale_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the array list engine.
// Depends on nothing; imported by the controller, the datapath and the top level.
package ale_pkg;

    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;
    localparam int CAP_W   = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // capacity_in_use sits at byte address 0; paddr[2] selects the word
    localparam logic CAP_WORD = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND   = 3'd0,
        CMD_INSERT   = 3'd1,
        CMD_REM_LAST = 3'd2,
        CMD_REM_AT   = 3'd3,
        CMD_GET      = 3'd4,
        CMD_FIND     = 3'd5,
        CMD_CLEAR    = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INS_SHIFT,
        ST_REM_SHIFT,
        ST_GET_WAIT,
        ST_FIND,
        ST_FINISH
    } state_t;

    // one datapath operation per cycle, issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_APPEND,
        DP_INS_PRIME,
        DP_INS_STEP,
        DP_INS_PUT,
        DP_CNT_DEC,
        DP_REM_PRIME,
        DP_REM_STEP,
        DP_GET_RD,
        DP_GET_TAKE,
        DP_FIND_PRIME,
        DP_FIND_STEP,
        DP_CLEAR,
        DP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        cmd_t cmd;
        logic can_add;            // count below effective capacity
        logic pos_le_count;
        logic pos_eq_count;
        logic pos_lt_count;
        logic pos_next_lt_count;  // pos + 1 < count
        logic count_zero;
        logic idx_eq_pos;
        logic idx1_lt_count;      // idx + 1 < count
        logic idx2_lt_count;      // idx + 2 < count
        logic hit;                // read word equals search value
        logic out_free;           // output register can take a new result
    } dp_status_t;

endpackage

// ===== rtl/ale_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the array list engine.
// Depends on ale_pkg; drives one datapath operation per cycle from datapath status.
module ale_ctrl
    import ale_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_op_t     op
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_FINISH;
                unique case (status.cmd)
                    CMD_INSERT:
                    begin
                        if (status.can_add && status.pos_le_count && !status.pos_eq_count)
                        begin
                            state_next = ST_INS_SHIFT;
                        end
                    end
                    CMD_REM_AT:
                    begin
                        if (status.pos_lt_count && status.pos_next_lt_count)
                        begin
                            state_next = ST_REM_SHIFT;
                        end
                    end
                    CMD_GET:
                    begin
                        if (status.pos_lt_count)
                        begin
                            state_next = ST_GET_WAIT;
                        end
                    end
                    CMD_FIND:
                    begin
                        if (!status.count_zero)
                        begin
                            state_next = ST_FIND;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_INS_SHIFT:
            begin
                if (status.idx_eq_pos)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_REM_SHIFT:
            begin
                if (!status.idx2_lt_count)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_GET_WAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_FIND:
            begin
                if (status.hit || !status.idx1_lt_count)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        op       = DP_NOP;
        in_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op = DP_LOAD;
                end
            end
            ST_DECODE:
            begin
                unique case (status.cmd)
                    CMD_APPEND:
                    begin
                        if (status.can_add)
                        begin
                            op = DP_APPEND;
                        end
                    end
                    CMD_INSERT:
                    begin
                        if (status.can_add && status.pos_le_count)
                        begin
                            // insert at the end is a plain append
                            op = status.pos_eq_count ? DP_APPEND : DP_INS_PRIME;
                        end
                    end
                    CMD_REM_LAST:
                    begin
                        if (!status.count_zero)
                        begin
                            op = DP_CNT_DEC;
                        end
                    end
                    CMD_REM_AT:
                    begin
                        if (status.pos_lt_count)
                        begin
                            op = status.pos_next_lt_count ? DP_REM_PRIME : DP_CNT_DEC;
                        end
                    end
                    CMD_GET:
                    begin
                        if (status.pos_lt_count)
                        begin
                            op = DP_GET_RD;
                        end
                    end
                    CMD_FIND:
                    begin
                        if (!status.count_zero)
                        begin
                            op = DP_FIND_PRIME;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        op = DP_CLEAR;
                    end
                    default:
                    begin
                        op = DP_NOP;
                    end
                endcase
            end
            ST_INS_SHIFT:
            begin
                op = status.idx_eq_pos ? DP_INS_PUT : DP_INS_STEP;
            end
            ST_REM_SHIFT:
            begin
                op = DP_REM_STEP;
            end
            ST_GET_WAIT:
            begin
                op = DP_GET_TAKE;
            end
            ST_FIND:
            begin
                op = DP_FIND_STEP;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    op = DP_OUT_LOAD;
                end
            end
            default:
            begin
                op = DP_NOP;
            end
        endcase
    end

endmodule

// ===== rtl/ale_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the array list engine: entry memory, count, walk index and output register.
// Depends on ale_pkg; executes the operation the controller issues each cycle.
module ale_datapath
    import ale_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_op_t                    op,
    output dp_status_t                status,
    input  logic [CAP_W-1:0]          cap,
    input  logic [CMD_W-1:0]          cmd,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [POS_W-1:0]          position,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      ok,
    output logic signed [VALUE_W-1:0] result_value,
    output logic [COUNT_W-1:0]        count,
    output logic                      is_empty,
    output logic                      is_full
);

    localparam int AW  = $clog2(DEPTH);
    localparam int NW  = $clog2(DEPTH + 1);
    localparam int CW  = (NW > POS_W) ? NW : POS_W;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_wa;
    logic [AW-1:0]      mem_ra;
    logic [VALUE_W-1:0] mem_wd;

    cmd_t               cmd_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [CW-1:0]      pos_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      idx_next;
    logic               ok_reg;
    logic               ok_next;
    logic [VALUE_W-1:0] res_reg;
    logic [VALUE_W-1:0] res_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_ok_reg;
    logic [VALUE_W-1:0] out_res_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_empty_reg;
    logic               out_full_reg;

    logic [CW-1:0]      cap_ext;
    logic [CW-1:0]      eff_cap;
    logic [CW:0]        pos_p1;
    logic [CW:0]        idx_p1;
    logic [CW:0]        idx_p2;
    logic [CW-1:0]      cnt_m1;
    logic [CW-1:0]      idx_m2;

    // clamp the capacity register to 1..DEPTH
    always_comb
    begin
        cap_ext = CW'(cap);
        priority if (cap_ext == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (cap_ext > CW'(DEPTH))
        begin
            eff_cap = CW'(DEPTH);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign pos_p1 = {1'b0, pos_reg} + (CW+1)'(1);
    assign idx_p1 = {1'b0, idx_reg} + (CW+1)'(1);
    assign idx_p2 = {1'b0, idx_reg} + (CW+1)'(2);
    assign cnt_m1 = count_reg - CW'(1);
    assign idx_m2 = idx_reg - CW'(2);

    always_comb
    begin
        status.cmd               = cmd_reg;
        status.can_add           = (count_reg < eff_cap);
        status.pos_le_count      = (pos_reg <= count_reg);
        status.pos_eq_count      = (pos_reg == count_reg);
        status.pos_lt_count      = (pos_reg < count_reg);
        status.pos_next_lt_count = (pos_p1 < {1'b0, count_reg});
        status.count_zero        = (count_reg == '0);
        status.idx_eq_pos        = (idx_reg == pos_reg);
        status.idx1_lt_count     = (idx_p1 < {1'b0, count_reg});
        status.idx2_lt_count     = (idx_p2 < {1'b0, count_reg});
        status.hit               = (rdata_reg == value_reg);
        status.out_free          = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        ok_next    = ok_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_wa     = idx_reg[AW-1:0];
        mem_wd     = rdata_reg;
        mem_re     = 1'b0;
        mem_ra     = '0;
        unique case (op)
            DP_NOP, DP_OUT_LOAD:
            begin
                count_next = count_reg;
            end
            DP_LOAD:
            begin
                ok_next  = 1'b0;
                res_next = '0;
            end
            DP_APPEND:
            begin
                mem_we     = 1'b1;
                mem_wa     = count_reg[AW-1:0];
                mem_wd     = value_reg;
                count_next = count_reg + CW'(1);
                ok_next    = 1'b1;
            end
            DP_INS_PRIME:
            begin
                mem_re   = 1'b1;
                mem_ra   = cnt_m1[AW-1:0];
                idx_next = count_reg;
            end
            DP_INS_STEP:
            begin
                // move entry idx-1 up to idx, fetch the next one down
                mem_we   = 1'b1;
                mem_wa   = idx_reg[AW-1:0];
                mem_wd   = rdata_reg;
                mem_re   = (idx_reg > pos_p1[CW-1:0]);
                mem_ra   = idx_m2[AW-1:0];
                idx_next = idx_reg - CW'(1);
            end
            DP_INS_PUT:
            begin
                mem_we     = 1'b1;
                mem_wa     = idx_reg[AW-1:0];
                mem_wd     = value_reg;
                count_next = count_reg + CW'(1);
                ok_next    = 1'b1;
            end
            DP_CNT_DEC:
            begin
                count_next = cnt_m1;
                ok_next    = 1'b1;
            end
            DP_REM_PRIME:
            begin
                mem_re   = 1'b1;
                mem_ra   = pos_p1[AW-1:0];
                idx_next = pos_reg;
            end
            DP_REM_STEP:
            begin
                // move entry idx+1 down to idx
                mem_we = 1'b1;
                mem_wa = idx_reg[AW-1:0];
                mem_wd = rdata_reg;
                if (status.idx2_lt_count)
                begin
                    mem_re   = 1'b1;
                    mem_ra   = idx_p2[AW-1:0];
                    idx_next = idx_p1[CW-1:0];
                end
                else
                begin
                    count_next = cnt_m1;
                    ok_next    = 1'b1;
                end
            end
            DP_GET_RD:
            begin
                mem_re = 1'b1;
                mem_ra = pos_reg[AW-1:0];
            end
            DP_GET_TAKE:
            begin
                res_next = rdata_reg;
                ok_next  = 1'b1;
            end
            DP_FIND_PRIME:
            begin
                mem_re   = 1'b1;
                mem_ra   = '0;
                idx_next = '0;
            end
            DP_FIND_STEP:
            begin
                if (status.hit)
                begin
                    res_next = VALUE_W'(idx_reg);
                    ok_next  = 1'b1;
                end
                else if (status.idx1_lt_count)
                begin
                    mem_re   = 1'b1;
                    mem_ra   = idx_p1[AW-1:0];
                    idx_next = idx_p1[CW-1:0];
                end
            end
            DP_CLEAR:
            begin
                count_next = '0;
                ok_next    = 1'b1;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign out_valid_next = (op == DP_OUT_LOAD) ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        ok_reg  <= ok_next;
        res_reg <= res_next;
        if (op == DP_LOAD)
        begin
            cmd_reg   <= cmd_t'(cmd);
            value_reg <= value;
            pos_reg   <= CW'(position);
        end
        if (op == DP_OUT_LOAD)
        begin
            out_ok_reg    <= ok_reg;
            out_res_reg   <= res_reg;
            out_count_reg <= count_reg[COUNT_W-1:0];
            out_empty_reg <= (count_reg == '0);
            out_full_reg  <= (count_reg >= eff_cap);
        end
    end

    assign out_valid    = out_valid_reg;
    assign ok           = out_ok_reg;
    assign result_value = out_res_reg;
    assign count        = out_count_reg;
    assign is_empty     = out_empty_reg;
    assign is_full      = out_full_reg;

endmodule

// ===== rtl/array_list_engine.sv =====
`timescale 1ns / 1ps
// Array list engine: one command in, one result beat out.
// Each command passes through decode and finish; get adds a read wait state, while insert
// below the count, remove at below the last entry and find walk the list one entry per
// cycle, find stopping at its first hit.
// One command at a time: the next input beat is taken once the result is in the output
// register; an output stall holds it there. Reset empties the list, capacity 16, no mem clear.
module array_list_engine
    import ale_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [CMD_W-1:0]          cmd,
    input  logic signed [VALUE_W-1:0] value,
    input  logic [POS_W-1:0]          position,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      ok,
    output logic signed [VALUE_W-1:0] result_value,
    output logic [COUNT_W-1:0]        count,
    output logic                      is_empty,
    output logic                      is_full
);

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;
    logic             cfg_write;
    dp_status_t       status;
    dp_op_t           op;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_write && (paddr[2] == CAP_WORD))
        begin
            cap_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    assign prdata = (paddr[2] == CAP_WORD) ? PDATA_W'(cap_reg) : '0;

    ale_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .op       (op)
    );

    ale_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .status       (status),
        .cap          (cap_reg),
        .cmd          (cmd),
        .value        (value),
        .position     (position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ok           (ok),
        .result_value (result_value),
        .count        (count),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

endmodule

// ===== sim/tb_array_list_engine.sv =====
`timescale 1ns / 1ps
// Self-checking bench for array_list_engine: directed list commands, then random phases.
// Predicts every result beat in-bench and checks it field by field; needs only ale_pkg and
// the RTL.
module tb_array_list_engine;
    import ale_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam logic [PADDR_W-1:0] CAP_ADDR = 3'd0;
    localparam logic [PADDR_W-1:0] SPARE_ADDR = 3'd4;
    localparam logic [VALUE_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic               empty;
        logic               full;
    } list_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [PDATA_W-1:0]        pwdata;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      in_valid;
    logic                      in_stall;
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    logic                      out_valid;
    logic                      out_stall;
    logic                      ok;
    logic signed [VALUE_W-1:0] result_value;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
    logic                      is_full;

    // predicted list contents and register
    logic [VALUE_W-1:0] list_words [DEPTH];
    int                 list_len;
    logic [CAP_W-1:0]   cap_setting;

    list_result_t pending_results [$];
    int unsigned  error_count;
    int unsigned  cmds_sent;
    int unsigned  results_checked;
    int unsigned  cfg_writes;
    int unsigned  cycle_count;
    int           hold_left;
    bit           idle_on;

    array_list_engine #(.DEPTH(DEPTH)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .value        (value),
        .position     (position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ok           (ok),
        .result_value (result_value),
        .count        (count),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("tb_array_list_engine NOT OK");
                $finish;
            end
        end
    end

    function automatic list_result_t apply_list_cmd(logic [CMD_W-1:0] c,
                                                    logic [VALUE_W-1:0] v,
                                                    logic [POS_W-1:0] p);
        list_result_t r;
        int           cap;
        int           pos;
        bit           found;
        r = '0;
        pos = int'(p);
        found = 1'b0;
        // clamp the register to 1..DEPTH
        cap = (cap_setting == 0) ? 1 : ((int'(cap_setting) > DEPTH) ? DEPTH : int'(cap_setting));
        case (c)
            CMD_APPEND:
                if (list_len < cap)
                begin
                    list_words[list_len] = v;
                    list_len++;
                    r.ok = 1'b1;
                end
            CMD_INSERT:
                if (pos <= list_len && list_len < cap)
                begin
                    for (int i = list_len; i > pos; i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = v;
                    list_len++;
                    r.ok = 1'b1;
                end
            CMD_REM_LAST:
                if (list_len > 0)
                begin
                    list_len--;
                    r.ok = 1'b1;
                end
            CMD_REM_AT:
                if (pos < list_len)
                begin
                    for (int i = pos; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    r.ok = 1'b1;
                end
            CMD_GET:
                if (pos < list_len)
                begin
                    r.value = list_words[pos];
                    r.ok = 1'b1;
                end
            CMD_FIND:
                for (int i = 0; i < list_len; i++)
                    if (!found && list_words[i] == v)
                    begin
                        found = 1'b1;
                        r.value = VALUE_W'(i);
                        r.ok = 1'b1;
                    end
            CMD_CLEAR:
            begin
                list_len = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.count = list_len[COUNT_W-1:0];
        r.empty = (list_len == 0);
        r.full = (list_len >= cap);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                   logic [VALUE_W-1:0] want);
        $display("mismatch on %s at result %0d: got %0h, expected %0h",
                 what, results_checked, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        list_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected beat", result_value, '0);
            else
            begin
                want = pending_results.pop_front();
                if (ok !== want.ok)
                    report_mismatch("ok", VALUE_W'(ok), VALUE_W'(want.ok));
                if (result_value !== want.value)
                    report_mismatch("result_value", result_value, want.value);
                if (count !== want.count)
                    report_mismatch("count", VALUE_W'(count), VALUE_W'(want.count));
                if (is_empty !== want.empty)
                    report_mismatch("is_empty", VALUE_W'(is_empty), VALUE_W'(want.empty));
                if (is_full !== want.full)
                    report_mismatch("is_full", VALUE_W'(is_full), VALUE_W'(want.full));
            end
            results_checked++;
        end
    end

    // receiver: long hold-off when asked, else random stalls while idles are on, else no stall
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (idle_on)
            out_stall <= ($urandom_range(99) < 25);
        else
            out_stall <= 1'b0;
    end

    task automatic send_item(logic [CMD_W-1:0] c, logic [VALUE_W-1:0] v,
                             logic [POS_W-1:0] p);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        value <= v;
        position <= p;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(apply_list_cmd(c, v, p));
        cmds_sent++;
    endtask

    // drop valid, wait out every result, then let the engine go quiet
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == CAP_ADDR)
            cap_setting = data[CAP_W-1:0];
        cfg_writes++;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_random_item();
        int               r;
        logic [CMD_W-1:0] c;
        logic [VALUE_W-1:0] v;
        logic [POS_W-1:0] p;
        r = $urandom_range(99);
        if (r < 22)
            c = CMD_APPEND;
        else if (r < 38)
            c = CMD_INSERT;
        else if (r < 48)
            c = CMD_REM_LAST;
        else if (r < 62)
            c = CMD_REM_AT;
        else if (r < 78)
            c = CMD_GET;
        else if (r < 94)
            c = CMD_FIND;
        else if (r < 97)
            c = CMD_CLEAR;
        else
            c = CMD_W'($urandom_range(7));

        r = $urandom_range(99);
        if (r < 20 && list_len > 0)
            v = list_words[$urandom_range(list_len - 1)];
        else if (r < 35)
            case ($urandom_range(3))
                0: v = WORD_MIN;
                1: v = WORD_MAX;
                2: v = '0;
                default: v = '1;
            endcase
        else
            v = $urandom;

        // mostly legal positions, some anywhere in the field
        if ($urandom_range(99) < 20)
            p = POS_W'($urandom_range(31));
        else if (c == CMD_INSERT)
            p = POS_W'($urandom_range(list_len));
        else
            p = POS_W'($urandom_range((list_len > 0) ? list_len - 1 : 0));
        send_item(c, v, p);
    endtask

    task automatic test_empty_list();
        send_item(CMD_REM_LAST, 32'd1, 5'd0);
        send_item(CMD_REM_AT, 32'd2, 5'd0);
        send_item(CMD_GET, 32'd3, 5'd0);
        send_item(CMD_FIND, 32'd0, 5'd0);
        send_item(CMD_UNUSED, WORD_MAX, 5'd31);
    endtask

    task automatic test_full_reject();
        settle_block();
        cfg_write(CAP_ADDR, 32'd3);
        send_item(CMD_APPEND, WORD_MIN, 5'd0);
        send_item(CMD_APPEND, WORD_MAX, 5'd0);
        send_item(CMD_INSERT, 32'd0, 5'd0);
        send_item(CMD_APPEND, '1, 5'd0);
        send_item(CMD_INSERT, 32'd5, 5'd1);
        send_item(CMD_FIND, WORD_MIN, 5'd0);
    endtask

    task automatic test_positions();
        settle_block();
        cfg_write(CAP_ADDR, 32'd16);
        send_item(CMD_CLEAR, 32'd0, 5'd0);
        send_item(CMD_APPEND, 32'd10, 5'd0);
        send_item(CMD_APPEND, 32'd20, 5'd0);
        send_item(CMD_INSERT, '1, 5'd1);
        send_item(CMD_INSERT, 32'd30, 5'd3);
        send_item(CMD_INSERT, 32'd40, 5'd5);
        send_item(CMD_GET, 32'd0, 5'd1);
        send_item(CMD_GET, 32'd0, 5'd31);
        send_item(CMD_FIND, 32'd30, 5'd0);
        send_item(CMD_REM_AT, 32'd0, 5'd0);
        send_item(CMD_REM_AT, 32'd0, 5'd9);
        send_item(CMD_REM_LAST, 32'd0, 5'd0);
    endtask

    // shrink capacity under a populated list; a write to the spare word must not land
    task automatic test_capacity_below_count();
        send_item(CMD_APPEND, 32'd7, 5'd0);
        send_item(CMD_APPEND, 32'd8, 5'd0);
        settle_block();
        cfg_write(CAP_ADDR, 32'd2);
        send_item(CMD_APPEND, 32'd9, 5'd0);
        settle_block();
        cfg_write(SPARE_ADDR, 32'd16);
        send_item(CMD_INSERT, 32'd9, 5'd0);
    endtask

    task automatic test_backpressure();
        settle_block();
        cfg_write(CAP_ADDR, 32'd16);
        hold_left = 300;
        repeat (10) send_random_item();
        settle_block();
    endtask

    task automatic test_random_phase(logic [CAP_W-1:0] cap_val, int n_items, bit idles);
        settle_block();
        cfg_write(CAP_ADDR, {27'd0, cap_val});
        idle_on = idles;
        repeat (n_items) send_random_item();
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        cmd = '0;
        value = '0;
        position = '0;
        out_stall = 1'b0;
        list_len = 0;
        cap_setting = CAP_RESET;
        error_count = 0;
        cmds_sent = 0;
        results_checked = 0;
        cfg_writes = 0;
        hold_left = 0;
        idle_on = 1'b1;
        for (int i = 0; i < DEPTH; i++)
            list_words[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_full_reject();
        test_positions();
        test_capacity_below_count();
        test_backpressure();
        test_random_phase(5'd16, 250, 1'b1);
        test_random_phase(5'd1, 100, 1'b1);
        test_random_phase(5'd5, 200, 1'b1);
        test_random_phase(5'd0, 100, 1'b1);
        test_random_phase(5'd31, 200, 1'b0);
        test_random_phase(5'd9, 200, 1'b1);
        test_random_phase(5'd16, 200, 1'b1);
        settle_block();

        $display("ran %0d list commands and checked %0d result beats", cmds_sent,
                 results_checked);
        $display("across %0d register writes, capacities 0 to 31, with stalls and hold-offs",
                 cfg_writes);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb_array_list_engine OK");
        else
            $display("tb_array_list_engine NOT OK");
        $finish;
    end

endmodule
